// File: rtl/rle8_pkg.sv
package rle8_pkg;

	localparam int COL_W         = 12;
	localparam int MAX_WIDTH_DEF = 4095;
	localparam logic [COL_W-1:0] ROW_WIDTH_RST = 12'd320;

	typedef enum logic [1:0] {
		EV_RUN = 2'd0,
		EV_EOL = 2'd1,
		EV_EOB = 2'd2,
		EV_ERR = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} code_item_t;

	typedef struct packed {
		event_kind_t      event_kind;
		logic [COL_W-1:0] start_column;
		logic [COL_W-1:0] run_length;
		logic [7:0]       color_index;
	} run_item_t;

endpackage

// File: rtl/rle8_if.sv
interface rle8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface rle8_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [11:0] start_column;
	logic [11:0] run_length;
	logic [7:0]  color_index;

	modport source (output valid, output event_kind, output start_column,
		output run_length, output color_index, input ready);
	modport sink   (input valid, input event_kind, input start_column,
		input run_length, input color_index, output ready);
endinterface

// File: rtl/rle8_core.sv
module rle8_core import rle8_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [COL_W-1:0] row_width,
	input  code_item_t       item,
	input  logic             advance,
	output logic             has_result,
	output run_item_t        result
);

	typedef enum logic [2:0] {
		PH_COUNT  = 3'd0,
		PH_COLOR  = 3'd1,
		PH_ESCAPE = 3'd2,
		PH_DX     = 3'd3,
		PH_DY     = 3'd4,
		PH_ABS    = 3'd5,
		PH_PAD    = 3'd6
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [COL_W-1:0] column_q, column_d;
	logic [7:0]       pending_q, pending_d;
	logic             odd_q, odd_d;
	logic [7:0]       delta_q, delta_d;

	logic [COL_W-1:0] eff_w;
	logic [COL_W-1:0] room;
	logic             do_run;
	logic [COL_W-1:0] run_n;
	logic [7:0]       pend_dec;

	always_comb begin
		if (32'(row_width) < 32'(MAX_WIDTH)) begin
			eff_w = row_width;
		end else begin
			eff_w = COL_W'(MAX_WIDTH);
		end
		room     = (column_q < eff_w) ? (eff_w - column_q) : '0;
		pend_dec = pending_q - 8'd1;
	end

	always_comb begin
		phase_d    = phase_q;
		column_d   = column_q;
		pending_d  = pending_q;
		odd_d      = odd_q;
		delta_d    = delta_q;
		has_result = 1'b0;
		do_run     = 1'b0;
		run_n      = '0;
		result.event_kind   = EV_RUN;
		result.start_column = column_q;
		result.run_length   = '0;
		result.color_index  = 8'd0;

		if (item.end_of_data) begin
			has_result        = 1'b1;
			result.event_kind = EV_ERR;
			phase_d   = PH_COUNT;
			column_d  = '0;
			pending_d = 8'd0;
			odd_d     = 1'b0;
			delta_d   = 8'd0;
		end else begin
			case (phase_q)
				PH_COLOR: begin
					phase_d            = PH_COUNT;
					do_run             = 1'b1;
					run_n              = COL_W'(pending_q);
					result.color_index = item.data_byte;
				end
				PH_ESCAPE: begin
					if (item.data_byte == 8'd0 || item.data_byte == 8'd1) begin
						// fill the rest of the row and start over
						has_result        = 1'b1;
						result.event_kind = (item.data_byte == 8'd0) ? EV_EOL : EV_EOB;
						result.run_length = room;
						column_d          = '0;
						phase_d           = PH_COUNT;
					end else if (item.data_byte == 8'd2) begin
						phase_d = PH_DX;
					end else begin
						pending_d = item.data_byte;
						odd_d     = item.data_byte[0];
						phase_d   = PH_ABS;
					end
				end
				PH_DX: begin
					delta_d = item.data_byte;
					phase_d = PH_DY;
				end
				PH_DY: begin
					// vertical offset dropped; skip columns with index 0
					phase_d = PH_COUNT;
					do_run  = 1'b1;
					run_n   = COL_W'(delta_q);
				end
				PH_ABS: begin
					pending_d = pend_dec;
					if (pend_dec == 8'd0) begin
						phase_d = odd_q ? PH_PAD : PH_COUNT;
					end
					do_run             = 1'b1;
					run_n              = COL_W'(1);
					result.color_index = item.data_byte;
				end
				PH_PAD: begin
					phase_d = PH_COUNT;
				end
				default: begin
					if (item.data_byte == 8'd0) begin
						phase_d = PH_ESCAPE;
					end else begin
						pending_d = item.data_byte;
						phase_d   = PH_COLOR;
					end
				end
			endcase
		end

		if (do_run) begin
			has_result        = 1'b1;
			result.run_length = (run_n < room) ? run_n : room;
			column_d          = column_q + result.run_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			column_q  <= '0;
			pending_q <= 8'd0;
			odd_q     <= 1'b0;
			delta_q   <= 8'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			column_q  <= column_d;
			pending_q <= pending_d;
			odd_q     <= odd_d;
			delta_q   <= delta_d;
		end
	end

endmodule

// File: rtl/rle8_row_decoder.sv
// RLE8 row decoder.
// Channel code carries one byte of the compressed stream per beat, with
// end_of_data marking the end of the stream. Channel run carries decoded
// events: pixel runs, end of line / end of bitmap fills, and an unexpected
// end error. row_width_we / row_width_wdata set the row width; write it
// only while no beat is in flight.
// A code beat is registered, decoded from that register and, if it
// yields an event, lands in the output register, from which it leaves
// as the run beat. Count, escape, delta dx and padding bytes yield no
// event. One byte is taken every cycle unless run stalls; the rate is
// set by the single decode stage between input and output registers.
// When run stalls, the output register holds its beat and the decode
// stage keeps at most one byte waiting; code ready drops only while a
// byte that yields an event cannot move on.
// Reset empties both registers, returns the parser to its row start and
// sets the row width to 320.
module rle8_row_decoder import rle8_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	rle8_in_if.sink          code,
	rle8_out_if.source       run,
	input  logic             row_width_we,
	input  logic [COL_W-1:0] row_width_wdata
);

	logic [COL_W-1:0] row_width_q;
	logic             valid_s1;
	code_item_t       item_s1;
	logic             valid_s2;
	run_item_t        result_s2;

	logic      has_result;
	run_item_t result;
	logic      out_free;
	logic      advance;

	assign out_free   = !valid_s2 || run.ready;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign code.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
		end else if (row_width_we) begin
			row_width_q <= row_width_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code.ready) begin
			valid_s1 <= code.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code.ready && code.valid) begin
			item_s1.data_byte   <= code.data_byte;
			item_s1.end_of_data <= code.end_of_data;
		end
	end

	rle8_core #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_width (row_width_q),
		.item      (item_s1),
		.advance   (advance),
		.has_result(has_result),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			result_s2 <= result;
		end
	end

	assign run.valid        = valid_s2;
	assign run.event_kind   = result_s2.event_kind;
	assign run.start_column = result_s2.start_column;
	assign run.run_length   = result_s2.run_length;
	assign run.color_index  = result_s2.color_index;

endmodule

// File: rtl/rle8_checker.sv
module rle8_checker import rle8_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        code_ready,
	input logic        run_valid,
	input logic        run_ready,
	input logic [1:0]  run_event_kind,
	input logic [11:0] run_start_column,
	input logic [11:0] run_run_length,
	input logic [7:0]  run_color_index
);

	// nothing leaves while reset is held
	a_no_beat_in_reset: assert property (@(posedge clk)
		!arst_n |-> !run_valid)
		else $error("run beat during reset");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!run_valid |-> code_ready)
		else $error("code stalled with empty output");

	// hold a stalled beat
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=> run_valid && $stable(run_event_kind)
			&& $stable(run_start_column) && $stable(run_run_length)
			&& $stable(run_color_index))
		else $error("stalled run beat changed");

	// fills and errors carry index 0; errors write no columns
	a_fill_color: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_event_kind != EV_RUN |-> run_color_index == 8'd0
			&& (run_event_kind != EV_ERR || run_run_length == 12'd0))
		else $error("bad fill or error event");

endmodule

bind rle8_row_decoder rle8_checker u_rle8_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.code_ready      (code.ready),
	.run_valid       (run.valid),
	.run_ready       (run.ready),
	.run_event_kind  (run.event_kind),
	.run_start_column(run.start_column),
	.run_run_length  (run.run_length),
	.run_color_index (run.color_index)
);
